/* rtl/kbst_pkg.sv */
// Shared types, codes and key maps for the keyboard scancode translator.
package kbst_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
	localparam int PADDR_W = 3;

	localparam logic [6:0] CODE_LSHIFT = 7'h2a;
	localparam logic [6:0] CODE_RSHIFT = 7'h36;
	localparam logic [6:0] CODE_CTRL = 7'h1d;
	localparam logic [6:0] CODE_C = 7'h2e;
	localparam logic [6:0] MAP_LAST = 7'h39;
	localparam logic [6:0] CHAR_ETX = 7'h03;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_BUSY = 2'd3;

	localparam logic [1:0] OP_EMIT = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [0:0] REG_OWNER_OPEN = 1'b0;
	localparam logic [0:0] REG_TTY_ATTACHED = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] kind;
		logic [6:0] ch;
		logic       pressed;
	} cmd_t;

	typedef logic [6:0] map_t [64];

	localparam map_t PLAIN_MAP = '{
		7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h7f, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam map_t SHIFT_MAP = '{
		7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h7f, 7'h00,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

/* rtl/kbst_front.sv */
// Front end: accepts transactions, tracks modifiers and classifies into commands.
module kbst_front import kbst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       owner_open,
	input  logic       tty_attached,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       mode,
	input  logic [7:0] scan_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic       shift_q;
	logic       ctrl_q;
	logic       accept;
	logic       released;
	logic [6:0] code;
	logic       shift_n;
	logic       ctrl_n;
	logic       in_map;
	logic [6:0] ch;
	logic [6:0] ev_ch;

	assign accept = in_valid && !in_stall;
	assign released = scan_byte[7];
	assign code = scan_byte[6:0];
	assign in_map = (code <= MAP_LAST);

	always_comb begin
		shift_n = shift_q;
		ctrl_n = ctrl_q;
		if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
			shift_n = !released;
		end
		if (code == CODE_CTRL) begin
			ctrl_n = !released;
		end
	end

	always_comb begin
		ch = '0;
		if (in_map) begin
			ch = shift_n ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
		end
		ev_ch = ((ch == '0) && (code == CODE_CTRL)) ? CODE_CTRL : ch;
	end

	always_comb begin
		cmd_push = 1'b0;
		cmd.op = OP_EMIT;
		cmd.kind = KIND_CHAR;
		cmd.ch = '0;
		cmd.pressed = 1'b0;
		if (accept) begin
			if (mode) begin
				cmd_push = 1'b1;
				if (owner_open) begin
					cmd.op = OP_READ;
				end else begin
					cmd.kind = KIND_BUSY;
				end
			end else if (!owner_open) begin
				if (tty_attached && !released) begin
					if (code == CODE_C && ctrl_n) begin
						cmd_push = 1'b1;
						cmd.ch = CHAR_ETX;
					end else if (ch != '0) begin
						cmd_push = 1'b1;
						cmd.ch = ch;
					end
				end
			end else if (in_map && ev_ch != '0) begin
				cmd_push = 1'b1;
				cmd.op = OP_PUSH;
				cmd.ch = ev_ch;
				cmd.pressed = !released;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q <= 1'b0;
		end else if (accept && !mode) begin
			shift_q <= shift_n;
			ctrl_q <= ctrl_n;
		end
	end

endmodule

/* rtl/kbst_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module kbst_cmd_fifo import kbst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	cmd_t               entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;

	assign full = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (CMDQ_AW+1)'(push) - (CMDQ_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

endmodule

/* rtl/kbst_back.sv */
// Back end: event ring, read handling and the registered result stage.
module kbst_back import kbst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [6:0] out_char,
	output logic       out_pressed
);

	logic [7:0]          event_queue [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] head_q;
	logic [QUEUE_AW-1:0] tail_q;
	logic [QUEUE_AW-1:0] head_next;
	logic [QUEUE_AW-1:0] tail_next;
	logic                ring_empty;
	logic                ring_full;
	logic                do_write;
	logic                do_read;
	logic [7:0]          rdata_q;
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [6:0]          char_q;
	logic                pressed_q;
	logic                from_mem_q;

	assign head_next = (head_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : tail_q + 1'b1;
	assign ring_empty = (head_q == tail_q);
	assign ring_full = (tail_next == head_q);

	assign cmd_pop = cmd_valid && (!out_valid_q || !out_stall);
	assign do_write = cmd_pop && (cmd.op == OP_PUSH) && !ring_full;
	assign do_read = cmd_pop && (cmd.op == OP_READ) && !ring_empty;

	always_ff @(posedge clk) begin
		if (do_write) begin
			event_queue[tail_q] <= {cmd.pressed, cmd.ch};
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rdata_q <= event_queue[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			out_valid_q <= 1'b0;
			from_mem_q <= 1'b0;
		end else begin
			if (do_write) begin
				tail_q <= tail_next;
			end
			if (do_read) begin
				head_q <= head_next;
			end
			if (cmd_pop) begin
				out_valid_q <= (cmd.op != OP_PUSH);
				from_mem_q <= do_read;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			unique case (cmd.op)
				OP_READ: begin
					kind_q <= ring_empty ? KIND_EMPTY : KIND_EVENT;
					char_q <= '0;
					pressed_q <= 1'b0;
				end
				default: begin
					kind_q <= cmd.kind;
					char_q <= cmd.ch;
					pressed_q <= cmd.pressed;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = kind_q;
	assign out_char = from_mem_q ? rdata_q[6:0] : char_q;
	assign out_pressed = from_mem_q ? rdata_q[7] : pressed_q;

	a_read_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> (out_valid_q && kind_q == KIND_EVENT && from_mem_q))
		else $error("ring read did not produce an event transaction");

	a_write_fills_ring: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> (head_q != tail_q))
		else $error("ring empty after event write");

	a_push_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.op == OP_PUSH) |=> !out_valid_q)
		else $error("event push produced a result");

endmodule

/* rtl/keyboard_scancode_translator_core.sv */
// Top level of the keyboard scancode translator: config registers and front/back wiring.
// An accepted input transaction is written into the command queue; the back end then pops
// it into the result register, which drives out_valid; out_stall can hold it in the queue.
// Throughput: one input transaction per cycle while in_stall is low; the event ring (one
// write or one registered read per cycle) and the result register sustain that rate.
// Reset clears modifiers, ring pointers, the command queue and config registers;
// ring contents are not cleared and no clearing pass runs.
module keyboard_scancode_translator_core import kbst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [7:0]         scan_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_kind,
	output logic [6:0]         out_char,
	output logic               out_pressed
);

	logic owner_open_q;
	logic tty_attached_q;
	logic cfg_write;
	logic cmd_push;
	cmd_t push_cmd;
	logic fifo_full;
	logic cmd_pop;
	logic cmd_valid;
	cmd_t pop_cmd;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_open_q <= 1'b0;
			tty_attached_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2:2])
				REG_OWNER_OPEN: owner_open_q <= pwdata[0];
				REG_TTY_ATTACHED: tty_attached_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2:2])
			REG_OWNER_OPEN: prdata[0] = owner_open_q;
			REG_TTY_ATTACHED: prdata[0] = tty_attached_q;
			default: prdata = '0;
		endcase
	end

	assign in_stall = fifo_full;

	kbst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.owner_open   (owner_open_q),
		.tty_attached (tty_attached_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.scan_byte    (scan_byte),
		.cmd_push     (cmd_push),
		.cmd          (push_cmd)
	);

	kbst_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (cmd_pop),
		.pop_valid (cmd_valid),
		.pop_cmd   (pop_cmd)
	);

	kbst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_char    (out_char),
		.out_pressed (out_pressed)
	);

endmodule

/* bench/keyboard_scancode_translator_core_tb.sv */
// Self-checking testbench for the keyboard scancode translator core.
module keyboard_scancode_translator_core_tb;
	import kbst_pkg::*;

	localparam int SETTLE = 6;
	localparam int LONG_HOLD = 90;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 70;
	localparam logic [PADDR_W-1:0] ADDR_OWNER_OPEN = {REG_OWNER_OPEN, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_TTY_ATTACHED = {REG_TTY_ATTACHED, 2'b00};

	localparam logic [6:0] BASE_KEYS [58] = '{
		7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2d, 7'h3d, 7'h7f, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
		7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00, 7'h00, 7'h20
	};

	localparam logic [6:0] SHIFTED_KEYS [58] = '{
		7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
		7'h28, 7'h29, 7'h5f, 7'h2b, 7'h7f, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
		7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00, 7'h00, 7'h20
	};

	typedef struct packed {
		logic       mode;
		logic [7:0] code_byte;
	} scan_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] ch;
		logic       pressed;
	} key_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = 1'b0;
	logic [7:0]         scan_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         out_kind;
	logic [6:0]         out_char;
	logic               out_pressed;

	keyboard_scancode_translator_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .scan_byte(scan_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
		.out_char(out_char), .out_pressed(out_pressed)
	);

	always #6 clk = ~clk;

	scan_item_t  scan_queue [$];
	key_result_t awaited_keys [$];

	logic       open_reg = 1'b0;
	logic       tty_reg = 1'b0;
	logic       shift_down = 1'b0;
	logic       ctrl_down = 1'b0;
	logic [7:0] ring [256];
	logic [7:0] evq_rd_idx = 8'd0;
	logic [7:0] evq_wr_idx = 8'd0;

	int mismatches = 0;
	int phase_items = 0;
	int hold_asks = 0;
	int hold_grants = 0;
	int idle_cycles = 0;

	function automatic void translate_scancode(input logic rd, input logic [7:0] sb);
		logic        released;
		logic [6:0]  code;
		logic [6:0]  ch;
		logic [7:0]  next_tail;
		key_result_t r;
		released = sb[7];
		code = sb[6:0];
		r.kind = KIND_CHAR;
		r.ch = 7'd0;
		r.pressed = 1'b0;
		if (rd) begin
			if (!open_reg) begin
				r.kind = KIND_BUSY;
			end else if (evq_rd_idx == evq_wr_idx) begin
				r.kind = KIND_EMPTY;
			end else begin
				r.kind = KIND_EVENT;
				r.ch = ring[evq_rd_idx][6:0];
				r.pressed = ring[evq_rd_idx][7];
				evq_rd_idx = evq_rd_idx + 8'd1;
			end
			awaited_keys.push_back(r);
		end else begin
			if (code == CODE_LSHIFT || code == CODE_RSHIFT)
				shift_down = !released;
			if (code == CODE_CTRL)
				ctrl_down = !released;
			ch = 7'd0;
			if (code <= MAP_LAST)
				ch = shift_down ? SHIFTED_KEYS[code] : BASE_KEYS[code];
			next_tail = evq_wr_idx + 8'd1;
			if (!open_reg) begin
				if (tty_reg && !released) begin
					if (code == CODE_C && ctrl_down) begin
						r.ch = CHAR_ETX;
						awaited_keys.push_back(r);
					end else if (ch != 7'd0) begin
						r.ch = ch;
						awaited_keys.push_back(r);
					end
				end
			end else if (code <= MAP_LAST && next_tail != evq_rd_idx) begin
				if (ch == 7'd0 && code == CODE_CTRL)
					ch = CODE_CTRL;
				if (ch != 7'd0) begin
					ring[evq_wr_idx] = {!released, ch};
					evq_wr_idx = next_tail;
				end
			end
		end
	endfunction

	// driver
	scan_item_t cur = '0;
	bit         offering = 1'b0;
	int         gap_left = 0;
	int         send_burst = 0;

	function automatic int pick_gap();
		int r;
		if (send_burst != 0) begin
			send_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 9);
		return $urandom_range(15, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (offering && !in_stall) begin
				translate_scancode(cur.mode, cur.code_byte);
				offering = 1'b0;
				gap_left = pick_gap();
			end
			if (!offering) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (scan_queue.size() != 0) begin
					cur = scan_queue.pop_front();
					offering = 1'b1;
				end
			end
			in_valid <= offering;
			mode <= cur.mode;
			scan_byte <= cur.code_byte;
		end
	end

	// monitor
	key_result_t want;
	bit          stall_now = 1'b0;
	int          stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_keys.size() == 0) begin
					$error("out_kind: expected none, got %0d (char %0h)", out_kind, out_char);
					mismatches++;
				end else begin
					want = awaited_keys.pop_front();
					if (out_kind !== want.kind) begin
						$error("out_kind: expected %0d, got %0d", want.kind, out_kind);
						mismatches++;
					end
					if (out_char !== want.ch) begin
						$error("out_char: expected %0h, got %0h", want.ch, out_char);
						mismatches++;
					end
					if (out_pressed !== want.pressed) begin
						$error("out_pressed: expected %0d, got %0d", want.pressed, out_pressed);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
			end else if (hold_grants != hold_asks) begin
				hold_grants++;
				stall_now = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_now) begin
				stall_now = 1'b0;
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
					: $urandom_range(0, 6);
			end else begin
				stall_now = 1'b1;
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40)
					: $urandom_range(0, 2);
			end
			out_stall <= stall_now;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_scan(input logic [7:0] b);
		scan_item_t it;
		it.mode = 1'b0;
		it.code_byte = b;
		scan_queue.push_back(it);
		phase_items++;
	endtask

	task automatic push_read();
		scan_item_t it;
		it.mode = 1'b1;
		it.code_byte = 8'($urandom_range(0, 255));
		scan_queue.push_back(it);
		phase_items++;
	endtask

	task automatic queue_keystroke(input bit with_reads);
		logic [6:0] key;
		logic [6:0] shift_code;
		bit         with_shift;
		bit         with_ctrl;
		key = 7'($urandom_range(0, MAP_LAST));
		shift_code = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
		with_shift = ($urandom_range(0, 3) == 0);
		with_ctrl = ($urandom_range(0, 5) == 0);
		if (with_ctrl && $urandom_range(0, 1))
			key = CODE_C;
		if (with_shift)
			push_scan({1'b0, shift_code});
		if (with_ctrl)
			push_scan({1'b0, CODE_CTRL});
		push_scan({1'b0, key});
		if ($urandom_range(0, 3) != 0)
			push_scan({1'b1, key});
		if (with_ctrl)
			push_scan({1'b1, CODE_CTRL});
		if (with_shift)
			push_scan({1'b1, shift_code});
		if (with_reads)
			repeat ($urandom_range(0, 4)) push_read();
	endtask

	task automatic wait_quiet();
		do @(negedge clk);
		while (scan_queue.size() != 0 || in_valid || awaited_keys.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic v);
		logic [31:0] data;
		data = $urandom;
		data[0] = v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_OWNER_OPEN)
			open_reg = v;
		else if (addr == ADDR_TTY_ATTACHED)
			tty_reg = v;
	endtask

	task automatic set_config(input logic owner_v, input logic tty_v);
		write_reg(ADDR_OWNER_OPEN, owner_v);
		write_reg(ADDR_TTY_ATTACHED, tty_v);
	endtask

	localparam logic PHASE_OWNER [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	localparam logic PHASE_TTY [8] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

	initial begin
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// no owner, no terminal: reads answer busy, keys vanish
		push_scan(8'h1e);
		push_read();
		push_scan({1'b0, CODE_LSHIFT});
		push_scan({1'b1, CODE_LSHIFT});
		wait_quiet();

		set_config(1'b0, 1'b1);
		push_scan(8'h00);
		push_scan(8'h7f);
		push_scan(8'hff);
		push_scan(8'h80);
		push_scan(8'h1e);
		push_scan(8'h9e);
		push_scan({1'b0, CODE_LSHIFT});
		push_scan(8'h1e);
		push_scan(8'h0f);
		push_scan({1'b1, CODE_LSHIFT});
		push_scan({1'b0, CODE_RSHIFT});
		push_scan(8'h02);
		push_scan({1'b1, CODE_RSHIFT});
		push_scan({1'b0, CODE_CTRL});
		push_scan({1'b0, CODE_C});
		push_scan({1'b1, CODE_CTRL});
		push_scan({1'b0, CODE_C});
		push_scan({1'b0, MAP_LAST});
		push_scan(8'h3a);
		push_scan(8'h01);
		push_read();
		wait_quiet();

		set_config(1'b1, 1'b0);
		push_read();
		push_scan({1'b0, CODE_CTRL});
		push_scan({1'b1, CODE_CTRL});
		push_scan(8'h1e);
		push_scan(8'h9e);
		push_scan({1'b0, CODE_LSHIFT});
		push_scan(8'h3a);
		push_scan(8'h00);
		repeat (6) push_read();
		wait_quiet();

		// fill the ring past full, then hold off the results while it drains
		repeat (258) push_scan(8'($urandom_range(8'h10, 8'h19)));
		hold_asks++;
		repeat (258) push_read();
		wait_quiet();

		for (int p = 0; p < 8; p++) begin
			set_config(PHASE_OWNER[p], PHASE_TTY[p]);
			if (p == 1)
				hold_asks++;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 78) begin
					queue_keystroke(PHASE_OWNER[p]);
				end else if (r < 82) begin
					repeat ($urandom_range(5, 25)) push_read();
				end else if (r < 92) begin
					if ($urandom_range(0, 1))
						push_read();
					else
						push_scan(8'($urandom_range(0, 255)));
				end else begin
					push_scan({1'b1, 7'($urandom_range(0, 127))});
				end
			end
			wait_quiet();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/kbst_pkg.sv
rtl/kbst_front.sv
rtl/kbst_cmd_fifo.sv
rtl/kbst_back.sv
rtl/keyboard_scancode_translator_core.sv
bench/keyboard_scancode_translator_core_tb.sv
